### hdl/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt package
// Shared types, constants and GF(2^8) byte and column functions.
// ----------------------------------------------------------------------------
package aesd_pkg;

  localparam int unsigned HALF_W   = 64;
  localparam int unsigned BLOCK_W  = 128;
  localparam int unsigned NR       = 10;
  localparam int unsigned NKEYS    = NR + 1;
  localparam logic [7:0]  GF_POLY  = 8'h1B;

  // register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_DONE
  } aesd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture ciphertext, start key expansion
    logic       expand;     // compute next round key
    logic       init_add;   // add last round key
    logic       round;      // perform one inverse round
    logic       last;       // final round, no InvMixColumns
    logic [3:0] key_wr_idx;
    logic [3:0] key_rd_idx;
  } aesd_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  // InvMixColumns on one 32-bit column, byte 0 in the top bits
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[31 - 8*i -: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

### hdl/aesd_stream_if.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
interface aesd_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

### hdl/aes128_block_decrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block decrypt
// Iterative inverse cipher with per-block key expansion into a round key RAM.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      handshake
//  cfg       in   wr_en, wr_index, wr_data     write on wr_en
//  cipher    in   data_high, data_low          valid/ready
//  plain     out  data_high, data_low          valid/ready
//
//  A request is taken in idle (load of block and key), then 10 key expansion
//  steps into the key RAM and the round phase (initial add and ten rounds);
//  the result is then valid and held until taken. One block at a time.
//  Synchronous active-high reset returns the controller to idle and clears the key registers.
//  The output stalls hold the result; input is not taken until it leaves.
module aes128_block_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [63:0] wr_data,
  aesd_stream_if.sink   cipher,
  aesd_stream_if.source plain
);
  import aesd_pkg::*;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  aesd_cmd_t    cmd;
  logic [127:0] result;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_HIGH: key_high <= wr_data;
        REG_KEY_LOW:  key_low  <= wr_data;
        default: ;
      endcase
    end
  end

  aesd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cipher.valid),
    .in_ready  (cipher.ready),
    .out_valid (plain.valid),
    .out_ready (plain.ready),
    .cmd       (cmd)
  );

  aesd_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .key_high    (key_high),
    .key_low     (key_low),
    .cipher_high (cipher.data_high),
    .cipher_low  (cipher.data_low),
    .state_out   (result)
  );

  assign plain.data_high = result[127:64];
  assign plain.data_low  = result[63:0];
endmodule

### hdl/aesd_ram.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aesd_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hdl/aesd_datapath.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt datapath
// Key expansion register, round key RAM and the inverse round state.
// ----------------------------------------------------------------------------
module aesd_datapath (
  input  logic                clk,
  input  aesd_pkg::aesd_cmd_t cmd,
  input  logic [63:0]         key_high,
  input  logic [63:0]         key_low,
  input  logic [63:0]         cipher_high,
  input  logic [63:0]         cipher_low,
  output logic [127:0]        state_out
);
  import aesd_pkg::*;

  logic [127:0] rkey;
  logic [127:0] rkey_next;
  logic [7:0]   rcon;
  logic [127:0] state;
  logic [127:0] state_next;
  logic [127:0] rk_rd;
  logic [127:0] shifted;
  logic [127:0] subbed;
  logic [127:0] keyed;
  logic [127:0] mixed;
  logic [127:0] ram_wdata;
  logic [31:0]  tw;

  // next round key from the current one
  always_comb begin
    tw = {sbox(rkey[23:16]) ^ rcon, sbox(rkey[15:8]), sbox(rkey[7:0]), sbox(rkey[31:24])};
    rkey_next[127:96] = rkey[127:96] ^ tw;
    rkey_next[95:64]  = rkey[95:64] ^ rkey_next[127:96];
    rkey_next[63:32]  = rkey[63:32] ^ rkey_next[95:64];
    rkey_next[31:0]   = rkey[31:0] ^ rkey_next[63:32];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rkey <= {key_high, key_low};
      rcon <= 8'h01;
    end else if (cmd.expand) begin
      rkey <= rkey_next;
      rcon <= xtime(rcon);
    end
  end

  assign ram_wdata = cmd.load ? {key_high, key_low} : rkey_next;

  aesd_ram #(.WIDTH(BLOCK_W), .DEPTH(NKEYS)) u_keys (
    .clk     (clk),
    .wr_en   (cmd.load | cmd.expand),
    .wr_addr (cmd.key_wr_idx),
    .wr_data (ram_wdata),
    .rd_addr (cmd.key_rd_idx),
    .rd_data (rk_rd)
  );

  // inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8*(4*((c + r) % 4) + r) -: 8] = state[127 - 8*(4*c + r) -: 8];
      end
    end
    for (int k = 0; k < 16; k++) begin
      subbed[127 - 8*k -: 8] = inv_sbox(shifted[127 - 8*k -: 8]);
    end
    keyed = subbed ^ rk_rd;
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = inv_mix_col(keyed[127 - 32*c -: 32]);
    end
    state_next = state;
    if (cmd.init_add) begin
      // last round key is still in the expansion register
      state_next = state ^ rkey;
    end else if (cmd.round) begin
      state_next = cmd.last ? keyed : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state <= {cipher_high, cipher_low};
    end else begin
      state <= state_next;
    end
  end

  assign state_out = state;
endmodule

### hdl/aesd_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt controller
// Sequences key expansion, initial key add and ten inverse rounds.
// ----------------------------------------------------------------------------
module aesd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output aesd_pkg::aesd_cmd_t cmd
);
  import aesd_pkg::*;

  aesd_state_t state, state_next;
  logic [3:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // cnt: key index written while expanding; round number while decrypting
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.key_wr_idx = 4'd0;
          cnt_next       = 4'd1;
          state_next     = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.expand     = 1'b1;
        cmd.key_wr_idx = cnt;
        if (cnt == 4'(NR)) begin
          cnt_next   = 4'd0;
          state_next = ST_ROUND;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_ROUND: begin
        // cnt 0: initial add with key NR from the expansion register;
        // each cycle reads the key for the next round
        cmd.init_add   = (cnt == 4'd0);
        cmd.round      = (cnt != 4'd0);
        cmd.last       = (cnt == 4'(NR));
        cmd.key_rd_idx = (cnt == 4'(NR)) ? 4'd0 : 4'(NR) - cnt - 4'd1;
        if (cnt == 4'(NR)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_rounds_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> cnt <= 4'(NR)) else $error("round count overrun");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_DONE) |-> $past(cmd.last)) else $error("done without last round");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("ready while busy");
endmodule
